// ===== hdl/mspfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mspfe_pkg
// Shared types, frame constants and the CRC-8 DVB-S2 byte update.
// ----------------------------------------------------------------------------
package mspfe_pkg;

    typedef struct packed {
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic [15:0] third_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_q_head;

    localparam int unsigned FRAME_LEN = 15;
    localparam int unsigned IDX_W     = 4;

    localparam logic [IDX_W-1:0] IDX_HDR0   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_HDR1   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_HDR2   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_FLAGS  = 4'd3;
    localparam logic [IDX_W-1:0] IDX_FUNC_L = 4'd4;
    localparam logic [IDX_W-1:0] IDX_FUNC_H = 4'd5;
    localparam logic [IDX_W-1:0] IDX_LEN_L  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_LEN_H  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_V0_L   = 4'd8;
    localparam logic [IDX_W-1:0] IDX_V0_H   = 4'd9;
    localparam logic [IDX_W-1:0] IDX_V1_L   = 4'd10;
    localparam logic [IDX_W-1:0] IDX_V1_H   = 4'd11;
    localparam logic [IDX_W-1:0] IDX_V2_L   = 4'd12;
    localparam logic [IDX_W-1:0] IDX_V2_H   = 4'd13;
    localparam logic [IDX_W-1:0] IDX_CRC    = 4'd14;

    localparam logic [7:0] HDR0_BYTE   = 8'h24; // '$'
    localparam logic [7:0] HDR1_BYTE   = 8'h58; // 'X'
    localparam logic [7:0] HDR2_BYTE   = 8'h3C; // '<'
    localparam logic [7:0] FLAGS_BYTE  = 8'h00;
    localparam logic [7:0] FUNC_L_BYTE = 8'h83;
    localparam logic [7:0] FUNC_H_BYTE = 8'h03;
    localparam logic [7:0] LEN_L_BYTE  = 8'h06;
    localparam logic [7:0] LEN_H_BYTE  = 8'h00;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mspfe_front.sv =====
// ----------------------------------------------------------------------------
// mspfe_front
// Accepts items on the start/busy handshake and queues them for the back end.
// ----------------------------------------------------------------------------
module mspfe_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mspfe_pkg::t_in_item i_item,
    input  logic                i_pop,
    output mspfe_pkg::t_q_head  o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mspfe_pkg::t_in_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                push;
    logic                pop;

    assign busy = (r_count == CNT_W'(DEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queued item lost");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == '0) || (r_count == CNT_W'(DEPTH))) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step with count");

endmodule

// ===== hdl/mspfe_back.sv =====
// ----------------------------------------------------------------------------
// mspfe_back
// Serializes one queued item into a 15-byte frame, CRC computed on the fly.
// ----------------------------------------------------------------------------
module mspfe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mspfe_pkg::t_q_head   i_head,
    output logic                 o_pop,
    output logic                 o_strobe,
    output mspfe_pkg::t_out_item o_result
);

    logic                          r_active, n_active;
    logic [mspfe_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]                    r_crc, n_crc;
    mspfe_pkg::t_in_item           r_item;
    logic [7:0]                    byte_sel;
    logic                          at_last;
    logic                          take;

    assign at_last = (r_idx == mspfe_pkg::IDX_CRC);
    assign take    = i_head.valid && (!r_active || at_last);
    assign o_pop   = take;

    always_comb begin
        unique case (r_idx)
            mspfe_pkg::IDX_HDR0:   byte_sel = mspfe_pkg::HDR0_BYTE;
            mspfe_pkg::IDX_HDR1:   byte_sel = mspfe_pkg::HDR1_BYTE;
            mspfe_pkg::IDX_HDR2:   byte_sel = mspfe_pkg::HDR2_BYTE;
            mspfe_pkg::IDX_FLAGS:  byte_sel = mspfe_pkg::FLAGS_BYTE;
            mspfe_pkg::IDX_FUNC_L: byte_sel = mspfe_pkg::FUNC_L_BYTE;
            mspfe_pkg::IDX_FUNC_H: byte_sel = mspfe_pkg::FUNC_H_BYTE;
            mspfe_pkg::IDX_LEN_L:  byte_sel = mspfe_pkg::LEN_L_BYTE;
            mspfe_pkg::IDX_LEN_H:  byte_sel = mspfe_pkg::LEN_H_BYTE;
            mspfe_pkg::IDX_V0_L:   byte_sel = r_item.first_value[7:0];
            mspfe_pkg::IDX_V0_H:   byte_sel = r_item.first_value[15:8];
            mspfe_pkg::IDX_V1_L:   byte_sel = r_item.second_value[7:0];
            mspfe_pkg::IDX_V1_H:   byte_sel = r_item.second_value[15:8];
            mspfe_pkg::IDX_V2_L:   byte_sel = r_item.third_value[7:0];
            mspfe_pkg::IDX_V2_H:   byte_sel = r_item.third_value[15:8];
            mspfe_pkg::IDX_CRC:    byte_sel = r_crc;
            default:               byte_sel = 8'h00;
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_crc    = r_crc;
        if (r_active) begin
            n_idx = r_idx + 1'b1;
            // CRC covers flags through the last payload byte
            if (r_idx >= mspfe_pkg::IDX_FLAGS && !at_last) begin
                n_crc = mspfe_pkg::crc8_update(r_crc, byte_sel);
            end
            if (at_last) begin
                n_active = 1'b0;
            end
        end
        if (take) begin
            n_active = 1'b1;
            n_idx    = '0;
            n_crc    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            o_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc                <= n_crc;
        o_result.frame_byte  <= byte_sel;
        o_result.last_byte   <= r_active && at_last;
        if (take) begin
            r_item <= i_head.item;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx <= mspfe_pkg::IDX_CRC))
        else $error("byte index past end of frame");

    a_no_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !at_last) |=> (r_active && r_idx == $past(r_idx) + 1'b1))
        else $error("frame cut short");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head.valid)
        else $error("pop from empty queue");

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.last_byte |-> o_strobe)
        else $error("last byte flag without strobe");

endmodule

// ===== hdl/mspv2_pointer_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// mspv2_pointer_frame_encoder
// MSPv2 request frame builder: three 16-bit values in, 15 frame bytes out.
// ----------------------------------------------------------------------------
// Input: an item (three 16-bit values) is taken at a rising edge with start
// high and busy low. Items go into a QUEUE_DEPTH-entry queue; busy is high
// only while that queue is full.
// Output: each frame byte shows on o_result for one cycle with o_strobe high;
// o_result.last_byte marks byte 14, the CRC-8 DVB-S2 over bytes 3..13.
// The receiver has no way to stall; bytes are sent one per cycle.
// Path: with the serializer idle, a taken item is written into the queue,
// then loaded from the queue head into the serializer, which registers
// byte 0 onto o_result. The byte serializer emits one byte per clock while
// a frame runs; with the next item already queued, frames follow with no gap.
// Reset (i_rst_n low, synchronous): queue emptied, serializer idle, strobe
// low. Any frame in flight is dropped.
// ----------------------------------------------------------------------------
module mspv2_pointer_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mspfe_pkg::t_in_item  i_item,
    output logic                 o_strobe,
    output mspfe_pkg::t_out_item o_result
);

    mspfe_pkg::t_q_head head;
    logic               pop;

    mspfe_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_head  (head)
    );

    mspfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
